// File: design/crcec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcec_pkg
// Shared constants and types for the CRC encoder / checker.
// ----------------------------------------------------------------------------
package crcec_pkg;

    // Default sizes of the block.
    localparam int MAX_GENERATOR_LENGTH_DEF = 17;
    localparam int CHARACTER_BITS_DEF       = 7;

    // Reset contents of the configuration registers (generator 1011, length 4).
    localparam int GENERATOR_BITS_RESET   = 11;
    localparam int GENERATOR_LENGTH_RESET = 4;

    // Smallest generator length in use.
    localparam int MIN_GENERATOR_LENGTH = 2;

    // Configuration register indexes.
    typedef enum logic {
        REG_GENERATOR_BITS   = 1'b0,
        REG_GENERATOR_LENGTH = 1'b1
    } t_cfg_reg;

    // Request codes.
    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_CHECK  = 1'b1
    } t_opcode;

endpackage : crcec_pkg
`default_nettype wire

// File: design/crc_encode_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_encode_check
// CRC encoder and checker by modulo-2 division with a configurable generator.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction is one request. An encode request carries a
// character; the block appends degree zero bits, divides and returns the
// remainder and the codeword. A check request carries a received codeword;
// the block returns the syndrome, a zero-syndrome flag and the dataword.
// Generator bits and length are set through the write port while idle.
// The division runs through a row of CHARACTER_BITS + MAX_GENERATOR_LENGTH - 1
// cells (23 by default), one message bit per cell, each cell registering its
// step, and one request is taken every cycle while o_stall is low.
// The cells hand transactions forward whenever the next one is empty or
// moving, so while the receiver stalls the row keeps filling until every
// cell holds a transaction; only then is o_stall raised. Results come out
// in request order.
// Reset loads generator 1011 with length 4 and empties the row.
// ----------------------------------------------------------------------------
module crc_encode_check #(
    parameter int MAX_GENERATOR_LENGTH = crcec_pkg::MAX_GENERATOR_LENGTH_DEF,
    parameter int CHARACTER_BITS       = crcec_pkg::CHARACTER_BITS_DEF,
    parameter int DW     = MAX_GENERATOR_LENGTH - 1,
    parameter int MSG_W  = CHARACTER_BITS + DW,
    parameter int LW     = $clog2(MAX_GENERATOR_LENGTH + 1),
    parameter int CFG_W  = (MAX_GENERATOR_LENGTH > LW) ? MAX_GENERATOR_LENGTH : LW
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic                       i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_opcode,
    input  wire logic [CHARACTER_BITS-1:0]  i_character,
    input  wire logic [MSG_W-1:0]           i_received_word,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic      [DW-1:0]              o_remainder,
    output logic      [MSG_W-1:0]           o_codeword_out,
    output logic                            o_syndrome_zero,
    output logic      [CHARACTER_BITS-1:0]  o_dataword
);
    import crcec_pkg::*;

    localparam int NSTEP = MSG_W;

    logic [DW-1:0]    gen;
    logic [DW-1:0]    dmask;
    logic [DW-1:0]    dtop;
    logic [MSG_W-1:0] nmask;
    logic [LW-1:0]    degree;

    logic                      s_valid [0:NSTEP];
    logic                      s_ready [0:NSTEP];
    logic                      s_op    [0:NSTEP];
    logic [MSG_W-1:0]          s_code  [0:NSTEP];
    logic [CHARACTER_BITS-1:0] s_data  [0:NSTEP];
    logic [DW-1:0]             s_rem   [0:NSTEP];

    logic [MSG_W-1:0] enc_code;
    logic [MSG_W-1:0] chk_code;

    crcec_cfg #(
        .MAX_GENERATOR_LENGTH (MAX_GENERATOR_LENGTH),
        .CHARACTER_BITS       (CHARACTER_BITS),
        .DW                   (DW),
        .MSG_W                (MSG_W),
        .LW                   (LW),
        .CFG_W                (CFG_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gen       (gen),
        .o_dmask     (dmask),
        .o_dtop      (dtop),
        .o_nmask     (nmask),
        .o_degree    (degree)
    );

    // The message is right-aligned in the full width with zeros above its
    // length; leading zeros leave the remainder at zero, so every request
    // passes through all cells.
    assign enc_code = MSG_W'(i_character) << degree;
    assign chk_code = i_received_word & nmask;

    always_comb begin
        s_valid[0] = i_valid;
        s_op[0]    = i_opcode;
        s_rem[0]   = '0;
        if (t_opcode'(i_opcode) == OP_ENCODE) begin
            s_code[0] = enc_code;
            s_data[0] = i_character;
        end else begin
            s_code[0] = chk_code;
            s_data[0] = CHARACTER_BITS'(chk_code >> degree);
        end
    end

    assign o_stall        = !s_ready[0];
    assign s_ready[NSTEP] = !i_stall;

    for (genvar k = 0; k < NSTEP; k++) begin : g_cell
        crcec_cell #(
            .DW      (DW),
            .CW      (CHARACTER_BITS),
            .MSG_W   (MSG_W),
            .BIT_POS (MSG_W - 1 - k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_gen      (gen),
            .i_dmask    (dmask),
            .i_dtop     (dtop),
            .i_valid    (s_valid[k]),
            .i_op       (s_op[k]),
            .i_code     (s_code[k]),
            .i_data     (s_data[k]),
            .i_rem      (s_rem[k]),
            .o_ready_up (s_ready[k]),
            .i_ready_dn (s_ready[k+1]),
            .o_valid    (s_valid[k+1]),
            .o_op       (s_op[k+1]),
            .o_code     (s_code[k+1]),
            .o_data     (s_data[k+1]),
            .o_rem      (s_rem[k+1])
        );
    end

    assign o_valid         = s_valid[NSTEP];
    assign o_remainder     = s_rem[NSTEP];
    assign o_syndrome_zero = (s_rem[NSTEP] == '0);
    assign o_dataword      = s_data[NSTEP];

    // For encode the low degree bits of the code are zero and take the remainder.
    assign o_codeword_out = (t_opcode'(s_op[NSTEP]) == OP_ENCODE)
                          ? (s_code[NSTEP] | MSG_W'(s_rem[NSTEP]))
                          : s_code[NSTEP];

    // The remainder never reaches above the current degree.
    a_rem_in_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_remainder & ~dmask) == '0))
        else $error("remainder has bits above the generator degree");

    // An empty first cell must always take a new transaction.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_valid[1] |-> !o_stall)
        else $error("input stalled while the first cell is empty");

    // Reset empties the cell row.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule : crc_encode_check
`default_nettype wire

// File: design/crcec_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcec_cfg
// Generator registers and the degree-dependent masks that the cells use.
// ----------------------------------------------------------------------------
module crcec_cfg #(
    parameter int MAX_GENERATOR_LENGTH = crcec_pkg::MAX_GENERATOR_LENGTH_DEF,
    parameter int CHARACTER_BITS       = crcec_pkg::CHARACTER_BITS_DEF,
    parameter int DW     = MAX_GENERATOR_LENGTH - 1,
    parameter int MSG_W  = CHARACTER_BITS + DW,
    parameter int LW     = $clog2(MAX_GENERATOR_LENGTH + 1),
    parameter int CFG_W  = (MAX_GENERATOR_LENGTH > LW) ? MAX_GENERATOR_LENGTH : LW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic      [DW-1:0]      o_gen,
    output logic      [DW-1:0]      o_dmask,
    output logic      [DW-1:0]      o_dtop,
    output logic      [MSG_W-1:0]   o_nmask,
    output logic      [LW-1:0]      o_degree
);
    import crcec_pkg::*;

    logic [MAX_GENERATOR_LENGTH-1:0] r_gen_bits;
    logic [LW-1:0]                   r_gen_len;
    logic [LW-1:0]                   len_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_bits <= MAX_GENERATOR_LENGTH'(GENERATOR_BITS_RESET);
            r_gen_len  <= LW'(GENERATOR_LENGTH_RESET);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GENERATOR_BITS:   r_gen_bits <= i_cfg_data[MAX_GENERATOR_LENGTH-1:0];
                REG_GENERATOR_LENGTH: r_gen_len  <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range lengths are pulled back to the nearest legal value.
    always_comb begin
        if (r_gen_len < LW'(MIN_GENERATOR_LENGTH)) begin
            len_used = LW'(MIN_GENERATOR_LENGTH);
        end else if (r_gen_len > LW'(MAX_GENERATOR_LENGTH)) begin
            len_used = LW'(MAX_GENERATOR_LENGTH);
        end else begin
            len_used = r_gen_len;
        end
    end

    assign o_degree = len_used - LW'(1);

    // The leading generator bit is implied by the division step, so only
    // the low bits are handed to the cells.
    assign o_gen = r_gen_bits[DW-1:0];

    always_comb begin
        for (int j = 0; j < DW; j++) begin
            o_dmask[j] = (j < int'(o_degree));
            o_dtop[j]  = (j == int'(o_degree) - 1);
        end
        for (int j = 0; j < MSG_W; j++) begin
            o_nmask[j] = (j < CHARACTER_BITS + int'(o_degree));
        end
    end

endmodule : crcec_cfg
`default_nettype wire

// File: design/crcec_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcec_cell
// One modulo-2 division step: shifts one message bit into the remainder and
// subtracts the generator when the bit shifted out is set.
// ----------------------------------------------------------------------------
module crcec_cell #(
    parameter int DW      = crcec_pkg::MAX_GENERATOR_LENGTH_DEF - 1,
    parameter int CW      = crcec_pkg::CHARACTER_BITS_DEF,
    parameter int MSG_W   = CW + DW,
    parameter int BIT_POS = MSG_W - 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [DW-1:0]      i_gen,
    input  wire logic [DW-1:0]      i_dmask,
    input  wire logic [DW-1:0]      i_dtop,
    input  wire logic               i_valid,
    input  wire logic               i_op,
    input  wire logic [MSG_W-1:0]   i_code,
    input  wire logic [CW-1:0]      i_data,
    input  wire logic [DW-1:0]      i_rem,
    output logic                    o_ready_up,
    input  wire logic               i_ready_dn,
    output logic                    o_valid,
    output logic                    o_op,
    output logic      [MSG_W-1:0]   o_code,
    output logic      [CW-1:0]      o_data,
    output logic      [DW-1:0]      o_rem
);
    import crcec_pkg::*;

    logic            r_valid;
    logic            r_op;
    logic [MSG_W-1:0] r_code;
    logic [CW-1:0]   r_data;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   n_rem;
    logic            lead;
    logic [DW:0]     shifted;

    // The cell takes a new transaction when it is empty or its content moves on.
    assign o_ready_up = !r_valid || i_ready_dn;

    always_comb begin
        lead    = |(i_rem & i_dtop);
        shifted = {i_rem, i_code[BIT_POS]};
        n_rem   = (shifted[DW-1:0] ^ ({DW{lead}} & i_gen)) & i_dmask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready_up && i_valid) begin
            r_op   <= i_op;
            r_code <= i_code;
            r_data <= i_data;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_code  = r_code;
    assign o_data  = r_data;
    assign o_rem   = r_rem;

endmodule : crcec_cell
`default_nettype wire
